// ----- rtl/core/lnte_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lnte_pkg
// Shared constants, sequencer codes and control/status types of the tick
// engine.
// ---------------------------------------------------------------------------
package lnte_pkg;

  localparam int NEURONS_DEF  = 1024;
  localparam int POPS_DEF     = 4;
  localparam int SYNAPSES_DEF = 65536;
  localparam int LIST_MAX_DEF = 63;

  localparam int CFG_W  = 11;
  localparam int CIDX_W = 2;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 16;
  localparam int REGN_W = 4;
  localparam int NOUT_W = 10;

  localparam logic [CIDX_W-1:0] CFG_COUNT = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_POP1  = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_POP2  = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_POP3  = 2'd3;

  localparam logic [CFG_W-1:0] COUNT_RST = 11'd1024;
  localparam logic [CFG_W-1:0] POP1_RST  = 11'd800;
  localparam logic [CFG_W-1:0] POP2_RST  = 11'd1024;
  localparam logic [CFG_W-1:0] POP3_RST  = 11'd1024;

  localparam logic [REGN_W-1:0] RG_VOLT   = 4'd0;
  localparam logic [REGN_W-1:0] RG_INPUT  = 4'd1;
  localparam logic [REGN_W-1:0] RG_DRIVE  = 4'd2;
  localparam logic [REGN_W-1:0] RG_START  = 4'd3;
  localparam logic [REGN_W-1:0] RG_LENGTH = 4'd4;
  localparam logic [REGN_W-1:0] RG_TARGET = 4'd5;
  localparam logic [REGN_W-1:0] RG_LEAK   = 4'd6;
  localparam logic [REGN_W-1:0] RG_GAIN   = 4'd7;
  localparam logic [REGN_W-1:0] RG_WEIGHT = 4'd8;
  localparam logic [REGN_W-1:0] RG_DECAY  = 4'd9;

  localparam int ST_W = 5;
  localparam logic [ST_W-1:0] ST_CLR  = 5'd0;
  localparam logic [ST_W-1:0] ST_IDLE = 5'd1;
  localparam logic [ST_W-1:0] ST_A0   = 5'd2;
  localparam logic [ST_W-1:0] ST_A1   = 5'd3;
  localparam logic [ST_W-1:0] ST_A2   = 5'd4;
  localparam logic [ST_W-1:0] ST_A3   = 5'd5;
  localparam logic [ST_W-1:0] ST_F0   = 5'd6;
  localparam logic [ST_W-1:0] ST_F1   = 5'd7;
  localparam logic [ST_W-1:0] ST_F2   = 5'd8;
  localparam logic [ST_W-1:0] ST_D0   = 5'd9;
  localparam logic [ST_W-1:0] ST_D1   = 5'd10;
  localparam logic [ST_W-1:0] ST_Q0   = 5'd11;
  localparam logic [ST_W-1:0] ST_Q1   = 5'd12;
  localparam logic [ST_W-1:0] ST_Q2   = 5'd13;
  localparam logic [ST_W-1:0] ST_Q3   = 5'd14;
  localparam logic [ST_W-1:0] ST_QE   = 5'd15;
  localparam logic [ST_W-1:0] ST_DONE = 5'd16;

  typedef struct packed {
    logic [ST_W-1:0] op;
    logic            go_tick;
    logic            go_write;
  } ctl_t;

  typedef struct packed {
    logic clr_end;
    logic n_lt;
    logic spike;
    logic fan_go;
    logic t_ok;
    logic w_nz;
    logic q_end;
  } sts_t;

endpackage
`default_nettype wire

// ----- rtl/core/lif_network_tick_engine_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lif_network_tick_engine_unit
// Tick engine for a network of leaky integrate-and-fire neurons.
//
// A request is taken when start is high and busy is low. Command 0 writes
// one table word (region, address, data). Command 1 runs one tick: for each
// neuron it updates the voltage, and for each spiking neuron it walks the
// fan-out entries and adds the pair weight to each target's current; then,
// for each neuron, it decays the current of every population with a nonzero
// pair weight and sums them with the drive into the next input. All tables
// sit behind one read port each and one shared 32x32 multiplier.
// Each spike is shown on out_neuron for one cycle under out_valid, in index
// order, up to LIST_MAX of them; a closing result with out_last carries the
// spike total and the overflow flag. The receiver cannot stall.
// After reset a clearing pass zeroes the voltage, input, current and
// coefficient tables, busy high; configuration writes are taken at any time.
// ---------------------------------------------------------------------------
module lif_network_tick_engine_unit #(
  parameter int NEURONS  = lnte_pkg::NEURONS_DEF,
  parameter int POPS     = lnte_pkg::POPS_DEF,
  parameter int SYNAPSES = lnte_pkg::SYNAPSES_DEF,
  parameter int LIST_MAX = lnte_pkg::LIST_MAX_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               in_command,
  input  wire logic [lnte_pkg::REGN_W-1:0]        in_region,
  input  wire logic [lnte_pkg::ADDR_W-1:0]        in_address,
  input  wire logic signed [lnte_pkg::DATA_W-1:0] in_data,
  output logic                                    out_valid,
  output logic [lnte_pkg::NOUT_W-1:0]             out_neuron,
  output logic [lnte_pkg::CFG_W-1:0]              out_spike_total,
  output logic                                    out_last,
  output logic                                    out_overflow,
  input  wire logic                               cfg_we,
  input  wire logic [lnte_pkg::CIDX_W-1:0]        cfg_index,
  input  wire logic [lnte_pkg::CFG_W-1:0]         cfg_data
);

  lnte_pkg::ctl_t ctl;
  lnte_pkg::sts_t sts;

  lnte_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .sts        (sts),
    .ctl        (ctl),
    .busy       (busy)
  );

  lnte_dpath #(
    .NEURONS  (NEURONS),
    .POPS     (POPS),
    .SYNAPSES (SYNAPSES),
    .LIST_MAX (LIST_MAX)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .sts             (sts),
    .in_region       (in_region),
    .in_address      (in_address),
    .in_data         (in_data),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_neuron      (out_neuron),
    .out_spike_total (out_spike_total),
    .out_last        (out_last),
    .out_overflow    (out_overflow)
  );

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_command) |=> busy)
    else $error("tick request did not raise busy");

  a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a running tick");

  a_spike_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (!out_overflow && out_spike_total == '0))
    else $error("spike result carries closing fields");

  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_valid)
    else $error("closing flag without strobe");

endmodule
`default_nettype wire

// ----- rtl/core/lnte_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lnte_ctrl
// Sequencer: clearing pass, table writes and the tick walk over neurons,
// fan-out entries and synaptic currents.
// ---------------------------------------------------------------------------
module lnte_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic          in_command,
  input  wire lnte_pkg::sts_t sts,
  output lnte_pkg::ctl_t     ctl,
  output logic               busy
);

  logic [lnte_pkg::ST_W-1:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lnte_pkg::ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lnte_pkg::ST_CLR:  if (sts.clr_end) state_nxt = lnte_pkg::ST_IDLE;
      lnte_pkg::ST_IDLE: if (start && in_command) state_nxt = lnte_pkg::ST_A0;
      lnte_pkg::ST_A0:   state_nxt = sts.n_lt ? lnte_pkg::ST_A1 : lnte_pkg::ST_D0;
      lnte_pkg::ST_A1:   state_nxt = lnte_pkg::ST_A2;
      lnte_pkg::ST_A2:   state_nxt = lnte_pkg::ST_A3;
      lnte_pkg::ST_A3:   state_nxt = sts.spike ? lnte_pkg::ST_F0 : lnte_pkg::ST_A0;
      lnte_pkg::ST_F0:   state_nxt = sts.fan_go ? lnte_pkg::ST_F1 : lnte_pkg::ST_A0;
      lnte_pkg::ST_F1:   state_nxt = sts.t_ok ? lnte_pkg::ST_F2 : lnte_pkg::ST_F0;
      lnte_pkg::ST_F2:   state_nxt = lnte_pkg::ST_F0;
      lnte_pkg::ST_D0:   state_nxt = sts.n_lt ? lnte_pkg::ST_D1 : lnte_pkg::ST_DONE;
      lnte_pkg::ST_D1:   state_nxt = lnte_pkg::ST_Q0;
      lnte_pkg::ST_Q0:   state_nxt = sts.q_end ? lnte_pkg::ST_QE : lnte_pkg::ST_Q1;
      lnte_pkg::ST_Q1:   state_nxt = sts.w_nz ? lnte_pkg::ST_Q2 : lnte_pkg::ST_Q0;
      lnte_pkg::ST_Q2:   state_nxt = lnte_pkg::ST_Q3;
      lnte_pkg::ST_Q3:   state_nxt = lnte_pkg::ST_Q0;
      lnte_pkg::ST_QE:   state_nxt = lnte_pkg::ST_D0;
      lnte_pkg::ST_DONE: state_nxt = lnte_pkg::ST_IDLE;
      default:           state_nxt = lnte_pkg::ST_IDLE;
    endcase
  end

  assign busy         = (state_r != lnte_pkg::ST_IDLE);
  assign ctl.op       = state_r;
  assign ctl.go_tick  = !busy && start && in_command;
  assign ctl.go_write = !busy && start && !in_command;

endmodule
`default_nettype wire

// ----- rtl/core/lnte_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lnte_dpath
// Tables, configuration registers, loop counters, one shared multiplier and
// the result register.
// ---------------------------------------------------------------------------
module lnte_dpath #(
  parameter int NEURONS  = lnte_pkg::NEURONS_DEF,
  parameter int POPS     = lnte_pkg::POPS_DEF,
  parameter int SYNAPSES = lnte_pkg::SYNAPSES_DEF,
  parameter int LIST_MAX = lnte_pkg::LIST_MAX_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire lnte_pkg::ctl_t                    ctl,
  output lnte_pkg::sts_t                         sts,
  input  wire logic [lnte_pkg::REGN_W-1:0]       in_region,
  input  wire logic [lnte_pkg::ADDR_W-1:0]       in_address,
  input  wire logic signed [lnte_pkg::DATA_W-1:0] in_data,
  input  wire logic                              cfg_we,
  input  wire logic [lnte_pkg::CIDX_W-1:0]       cfg_index,
  input  wire logic [lnte_pkg::CFG_W-1:0]        cfg_data,
  output logic                                   out_valid,
  output logic [lnte_pkg::NOUT_W-1:0]            out_neuron,
  output logic [lnte_pkg::CFG_W-1:0]             out_spike_total,
  output logic                                   out_last,
  output logic                                   out_overflow
);

  localparam int NI      = $clog2(NEURONS);
  localparam int NW      = $clog2(NEURONS + 1);
  localparam int SDEPTH  = POPS * NEURONS;
  localparam int SIW     = $clog2(SDEPTH);
  localparam int SW      = $clog2(SYNAPSES);
  localparam int POP_W   = (POPS > 1) ? $clog2(POPS) : 1;
  localparam int QW      = $clog2(POPS + 1);
  localparam int GAIN_B  = POPS;
  localparam int WGT_B   = 2 * POPS;
  localparam int DEC_B   = 2 * POPS + POPS * POPS;
  localparam int CDEPTH  = 2 * POPS + 2 * POPS * POPS;
  localparam int CAW     = $clog2(CDEPTH);
  localparam int CLR_LEN = (SDEPTH > CDEPTH) ? SDEPTH : CDEPTH;
  localparam int CLW     = $clog2(CLR_LEN + 1);
  localparam int LW      = $clog2(LIST_MAX + 1);
  localparam int AW      = 42;

  logic [lnte_pkg::CFG_W-1:0] count_cfg_r, pop1_r, pop2_r, pop3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_cfg_r <= lnte_pkg::COUNT_RST;
      pop1_r      <= lnte_pkg::POP1_RST;
      pop2_r      <= lnte_pkg::POP2_RST;
      pop3_r      <= lnte_pkg::POP3_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lnte_pkg::CFG_COUNT: count_cfg_r <= cfg_data;
        lnte_pkg::CFG_POP1:  pop1_r      <= cfg_data;
        lnte_pkg::CFG_POP2:  pop2_r      <= cfg_data;
        lnte_pkg::CFG_POP3:  pop3_r      <= cfg_data;
        default:             ;
      endcase
    end
  end

  function automatic logic [POP_W-1:0] pop_of(input logic [31:0] x,
                                              input logic [lnte_pkg::CFG_W-1:0] s1,
                                              input logic [lnte_pkg::CFG_W-1:0] s2,
                                              input logic [lnte_pkg::CFG_W-1:0] s3);
    logic [POP_W-1:0] p;
    p = '0;
    if (POPS > 1 && x >= 32'(s1)) p = POP_W'(1);
    if (POPS > 2 && x >= 32'(s2)) p = POP_W'(2);
    if (POPS > 3 && x >= 32'(s3)) p = POP_W'(3);
    return p;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [AW-1:0] v);
    logic signed [31:0] r;
    if (v > 42'sh0007FFFFFFF) r = 32'sh7FFFFFFF;
    else if (v < -42'sh00080000000) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [AW-1:0] sx(input logic signed [31:0] a);
    return {{(AW-32){a[31]}}, a};
  endfunction

  // memories
  logic signed [31:0] v_mem   [NEURONS];
  logic signed [31:0] i_mem   [NEURONS];
  logic signed [31:0] d_mem   [NEURONS];
  logic [15:0]        st_mem  [NEURONS];
  logic [15:0]        ln_mem  [NEURONS];
  logic [9:0]         tg_mem  [SYNAPSES];
  logic signed [31:0] s_mem   [SDEPTH];
  logic signed [31:0] c_mem   [CDEPTH];

  logic signed [31:0] v_rd_r, i_rd_r, d_rd_r, s_rd_r, c_rd_r;
  logic [15:0]        st_rd_r, ln_rd_r;
  logic [9:0]         t_rd_r;

  logic [NW-1:0]        n_r;
  logic [16:0]          l_r, e_r;
  logic [QW-1:0]        q_r;
  logic [LW-1:0]        listed_r;
  logic [lnte_pkg::CFG_W-1:0] spikes_r;
  logic [CLW-1:0]       clr_r;
  logic signed [AW-1:0] acc_r;
  logic signed [63:0]   prod_r;

  logic [NW-1:0]        count_w;
  logic [NI-1:0]        n_idx;
  logic [POP_W-1:0]     p_n, p_t;
  logic signed [39:0]   ps;
  logic signed [31:0]   vnew, cdec, mb;
  logic                 spike, emit;
  logic [SIW-1:0]       s_ra, s_wa;
  logic [CAW-1:0]       c_ra, c_wa;
  logic                 s_we, c_we, v_we, i_we;
  logic signed [31:0]   s_wd, c_wd, v_wd, i_wd;
  logic [NI-1:0]        v_wa, i_wa, w_na;
  logic                 a_n_ok, a_s_ok, a_p_ok, a_pp_ok, wr;
  logic [16:0]          fan_end;

  assign count_w = (32'(count_cfg_r) > 32'(NEURONS)) ? NW'(NEURONS) : NW'(count_cfg_r);
  assign n_idx   = n_r[NI-1:0];
  assign p_n     = pop_of(32'(n_r), pop1_r, pop2_r, pop3_r);
  assign p_t     = pop_of(32'(t_rd_r), pop1_r, pop2_r, pop3_r);
  assign ps      = prod_r[63:24];
  assign vnew    = sat32(acc_r - {{(AW-40){ps[39]}}, ps});
  assign cdec    = sat32({{(AW-40){ps[39]}}, ps});
  assign spike   = (vnew >= 32'sh01000000);
  assign emit    = (ctl.op == lnte_pkg::ST_A3) && spike && (32'(listed_r) < 32'(LIST_MAX));
  assign fan_end = 17'(st_rd_r) + 17'(ln_rd_r);

  assign sts.clr_end = (32'(clr_r) >= 32'(CLR_LEN - 1));
  assign sts.n_lt    = (n_r < count_w);
  assign sts.spike   = spike;
  assign sts.fan_go  = (l_r < e_r) && (32'(l_r) < 32'(SYNAPSES));
  assign sts.t_ok    = (32'(t_rd_r) < 32'(count_w));
  assign sts.w_nz    = (c_rd_r != 32'sd0);
  assign sts.q_end   = (32'(q_r) >= 32'(POPS));

  assign wr      = ctl.go_write;
  assign w_na    = NI'(in_address);
  assign a_n_ok  = (32'(in_address) < 32'(NEURONS));
  assign a_s_ok  = (32'(in_address) < 32'(SYNAPSES));
  assign a_p_ok  = (32'(in_address) < 32'(POPS));
  assign a_pp_ok = (32'(in_address) < 32'(POPS * POPS));

  // read address and multiplier operand selection
  always_comb begin
    if (ctl.op == lnte_pkg::ST_F1 || ctl.op == lnte_pkg::ST_F2) begin
      s_ra = SIW'(32'(p_n) * 32'(NEURONS) + 32'(t_rd_r));
    end else begin
      s_ra = SIW'(32'(q_r) * 32'(NEURONS) + 32'(n_r));
    end
    unique case (ctl.op)
      lnte_pkg::ST_A0: c_ra = CAW'(GAIN_B + 32'(p_n));
      lnte_pkg::ST_A1: c_ra = CAW'(32'(p_n));
      lnte_pkg::ST_F1: c_ra = CAW'(WGT_B + 32'(p_t) * POPS + 32'(p_n));
      lnte_pkg::ST_Q0: c_ra = CAW'(WGT_B + 32'(p_n) * POPS + 32'(q_r));
      lnte_pkg::ST_Q1: c_ra = CAW'(DEC_B + 32'(p_n) * POPS + 32'(q_r));
      default:         c_ra = '0;
    endcase
    unique case (ctl.op)
      lnte_pkg::ST_A1: mb = i_rd_r;
      lnte_pkg::ST_A2: mb = v_rd_r;
      default:         mb = s_rd_r;
    endcase
  end

  // write port selection
  always_comb begin
    v_we = 1'b0; v_wa = n_idx; v_wd = vnew;
    i_we = 1'b0; i_wa = n_idx; i_wd = sat32(acc_r);
    s_we = 1'b0; s_wa = s_ra;  s_wd = cdec;
    c_we = 1'b0; c_wa = '0;    c_wd = in_data;
    if (ctl.op == lnte_pkg::ST_CLR) begin
      v_we = (32'(clr_r) < 32'(NEURONS));
      v_wa = NI'(clr_r); v_wd = '0;
      i_we = v_we; i_wa = NI'(clr_r); i_wd = '0;
      s_we = (32'(clr_r) < 32'(SDEPTH));
      s_wa = SIW'(clr_r); s_wd = '0;
      c_we = (32'(clr_r) < 32'(CDEPTH));
      c_wa = CAW'(clr_r); c_wd = '0;
    end else if (wr) begin
      v_we = (in_region == lnte_pkg::RG_VOLT) && a_n_ok;
      v_wa = w_na; v_wd = in_data;
      i_we = (in_region == lnte_pkg::RG_INPUT) && a_n_ok;
      i_wa = w_na; i_wd = in_data;
      priority if (in_region == lnte_pkg::RG_LEAK) begin
        c_we = a_p_ok; c_wa = CAW'(in_address);
      end else if (in_region == lnte_pkg::RG_GAIN) begin
        c_we = a_p_ok; c_wa = CAW'(GAIN_B + 32'(in_address));
      end else if (in_region == lnte_pkg::RG_WEIGHT) begin
        c_we = a_pp_ok; c_wa = CAW'(WGT_B + 32'(in_address));
      end else if (in_region == lnte_pkg::RG_DECAY) begin
        c_we = a_pp_ok; c_wa = CAW'(DEC_B + 32'(in_address));
      end else begin
        c_we = 1'b0;
      end
    end else begin
      v_we = (ctl.op == lnte_pkg::ST_A3);
      v_wd = spike ? 32'sd0 : vnew;
      i_we = (ctl.op == lnte_pkg::ST_QE);
      s_we = (ctl.op == lnte_pkg::ST_F2) || (ctl.op == lnte_pkg::ST_Q3);
      s_wd = (ctl.op == lnte_pkg::ST_F2) ? sat32(sx(s_rd_r) + sx(c_rd_r)) : cdec;
    end
  end

  always_ff @(posedge clk) begin
    if (v_we) v_mem[v_wa] <= v_wd;
    v_rd_r <= v_mem[n_idx];
  end

  always_ff @(posedge clk) begin
    if (i_we) i_mem[i_wa] <= i_wd;
    i_rd_r <= i_mem[n_idx];
  end

  always_ff @(posedge clk) begin
    if (wr && in_region == lnte_pkg::RG_DRIVE && a_n_ok) d_mem[w_na] <= in_data;
    d_rd_r <= d_mem[n_idx];
  end

  always_ff @(posedge clk) begin
    if (wr && in_region == lnte_pkg::RG_START && a_n_ok) st_mem[w_na] <= in_data[15:0];
    st_rd_r <= st_mem[n_idx];
  end

  always_ff @(posedge clk) begin
    if (wr && in_region == lnte_pkg::RG_LENGTH && a_n_ok) ln_mem[w_na] <= in_data[15:0];
    ln_rd_r <= ln_mem[n_idx];
  end

  always_ff @(posedge clk) begin
    if (wr && in_region == lnte_pkg::RG_TARGET && a_s_ok) begin
      tg_mem[SW'(in_address)] <= in_data[9:0];
    end
    t_rd_r <= tg_mem[SW'(l_r)];
  end

  always_ff @(posedge clk) begin
    if (s_we) s_mem[s_wa] <= s_wd;
    s_rd_r <= s_mem[s_ra];
  end

  always_ff @(posedge clk) begin
    if (c_we) c_mem[c_wa] <= c_wd;
    c_rd_r <= c_mem[c_ra];
  end

  always_ff @(posedge clk) begin
    prod_r <= 64'(c_rd_r) * 64'(mb);
    unique case (ctl.op)
      lnte_pkg::ST_A2: acc_r <= sx(v_rd_r) + {{(AW-40){ps[39]}}, ps};
      lnte_pkg::ST_D1: acc_r <= sx(d_rd_r);
      lnte_pkg::ST_Q3: acc_r <= acc_r + sx(cdec);
      default:         acc_r <= acc_r;
    endcase
    if (ctl.op == lnte_pkg::ST_A3) begin
      l_r <= 17'(st_rd_r);
      e_r <= fan_end;
    end else if ((ctl.op == lnte_pkg::ST_F1 && !sts.t_ok) || ctl.op == lnte_pkg::ST_F2) begin
      l_r <= l_r + 17'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r    <= '0;
      n_r      <= '0;
      q_r      <= '0;
      listed_r <= '0;
      spikes_r <= '0;
    end else begin
      if (ctl.op == lnte_pkg::ST_CLR) clr_r <= clr_r + CLW'(1);
      if (ctl.go_tick) begin
        n_r      <= '0;
        listed_r <= '0;
        spikes_r <= '0;
      end
      unique case (ctl.op)
        lnte_pkg::ST_A0: if (!sts.n_lt) n_r <= '0;
        lnte_pkg::ST_A3: begin
          if (spike) begin
            if (spikes_r != '1) spikes_r <= spikes_r + 11'd1;
            if (emit) listed_r <= listed_r + LW'(1);
          end else begin
            n_r <= n_r + NW'(1);
          end
        end
        lnte_pkg::ST_F0: if (!sts.fan_go) n_r <= n_r + NW'(1);
        lnte_pkg::ST_D0: q_r <= '0;
        lnte_pkg::ST_Q1: if (!sts.w_nz) q_r <= q_r + QW'(1);
        lnte_pkg::ST_Q3: q_r <= q_r + QW'(1);
        lnte_pkg::ST_QE: n_r <= n_r + NW'(1);
        default:         ;
      endcase
    end
  end

  // result register
  logic                       ov_r, last_r, val_r;
  logic [lnte_pkg::NOUT_W-1:0] neu_r;
  logic [lnte_pkg::CFG_W-1:0]  tot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= 1'b0;
    end else begin
      val_r <= emit || (ctl.op == lnte_pkg::ST_DONE);
    end
    if (ctl.op == lnte_pkg::ST_DONE) begin
      neu_r  <= '0;
      tot_r  <= spikes_r;
      last_r <= 1'b1;
      ov_r   <= (32'(spikes_r) > 32'(LIST_MAX));
    end else begin
      neu_r  <= lnte_pkg::NOUT_W'(n_r);
      tot_r  <= '0;
      last_r <= 1'b0;
      ov_r   <= 1'b0;
    end
  end

  assign out_valid       = val_r;
  assign out_neuron      = neu_r;
  assign out_spike_total = tot_r;
  assign out_last        = last_r;
  assign out_overflow    = ov_r;

endmodule
`default_nettype wire

// ----- tb/tb_lif_network_tick_engine_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_lif_network_tick_engine_unit
// Self-checking bench for the neuron network tick engine. Table writes and
// tick requests are sent through the start/busy handshake, and a model of
// the network in the bench predicts every spike result and closing result.
// A short directed table covers extremes and ignored writes; random phases
// under several population/count settings follow.
// ---------------------------------------------------------------------------
module tb_lif_network_tick_engine_unit;

  localparam bit CMD_WRITE = 1'b0;
  localparam bit CMD_TICK  = 1'b1;
  localparam int NN = lnte_pkg::NEURONS_DEF;
  localparam int NP = lnte_pkg::POPS_DEF;
  localparam int NS = lnte_pkg::SYNAPSES_DEF;
  localparam int LMAX = lnte_pkg::LIST_MAX_DEF;
  localparam int GAIN_OFS = NP;
  localparam int WGT_OFS = 2 * NP;
  localparam int DCY_OFS = 2 * NP + NP * NP;
  localparam int ONE_Q = 1 << 24;
  localparam int CYCLE_LIMIT = 40000000;

  typedef struct {
    bit [lnte_pkg::NOUT_W-1:0] neuron;
    bit [lnte_pkg::CFG_W-1:0]  total;
    bit                        last;
    bit                        ovf;
  } spike_res_t;

  typedef struct {
    bit                        cmd;
    bit [lnte_pkg::REGN_W-1:0] region;
    bit [lnte_pkg::ADDR_W-1:0] addr;
    bit [31:0]                 data;
    bit                        typed;
    bit [lnte_pkg::CFG_W-1:0]  typed_total;
    bit                        typed_ovf;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_command = 1'b0;
  logic [lnte_pkg::REGN_W-1:0] in_region = '0;
  logic [lnte_pkg::ADDR_W-1:0] in_address = '0;
  logic signed [lnte_pkg::DATA_W-1:0] in_data = '0;
  logic out_valid;
  logic [lnte_pkg::NOUT_W-1:0] out_neuron;
  logic [lnte_pkg::CFG_W-1:0] out_spike_total;
  logic out_last;
  logic out_overflow;
  logic cfg_we = 1'b0;
  logic [lnte_pkg::CIDX_W-1:0] cfg_index = '0;
  logic [lnte_pkg::CFG_W-1:0] cfg_data = '0;

  lif_network_tick_engine_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_region(in_region), .in_address(in_address),
    .in_data(in_data), .out_valid(out_valid), .out_neuron(out_neuron),
    .out_spike_total(out_spike_total), .out_last(out_last),
    .out_overflow(out_overflow), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // network mirror
  int volt [NN];
  int inp [NN];
  int drv [NN];
  int cur [NP*NN];
  bit [15:0] fstart [NN];
  bit [15:0] flen [NN];
  bit [9:0] tgt [NS];
  int coef [DCY_OFS + NP*NP];
  bit [lnte_pkg::CFG_W-1:0] m_count = lnte_pkg::COUNT_RST;
  bit [lnte_pkg::CFG_W-1:0] m_pop1 = lnte_pkg::POP1_RST;
  bit [lnte_pkg::CFG_W-1:0] m_pop2 = lnte_pkg::POP2_RST;
  bit [lnte_pkg::CFG_W-1:0] m_pop3 = lnte_pkg::POP3_RST;

  spike_res_t spike_q[$];
  int errors = 0;
  int cycles = 0;
  int n_writes = 0;
  int n_ticks = 0;
  int n_results = 0;
  bit idle_on = 1'b1;

  function automatic int sat32(longint v);
    if (v > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -64'sh80000000) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic longint mul_q(int a, int b);
    longint p;
    p = longint'(a) * longint'(b);
    return p >>> 24;
  endfunction

  function automatic int pop_of(int n);
    int p;
    p = 0;
    if (n >= m_pop1) p = 1;
    if (n >= m_pop2) p = 2;
    if (n >= m_pop3) p = 3;
    return p;
  endfunction

  task automatic table_write(bit [lnte_pkg::REGN_W-1:0] rg, bit [lnte_pkg::ADDR_W-1:0] a,
                             bit [31:0] d);
    case (rg)
      lnte_pkg::RG_VOLT:   if (a < NN) volt[a] = int'(d);
      lnte_pkg::RG_INPUT:  if (a < NN) inp[a] = int'(d);
      lnte_pkg::RG_DRIVE:  if (a < NN) drv[a] = int'(d);
      lnte_pkg::RG_START:  if (a < NN) fstart[a] = d[15:0];
      lnte_pkg::RG_LENGTH: if (a < NN) flen[a] = d[15:0];
      lnte_pkg::RG_TARGET: tgt[a] = d[9:0];
      lnte_pkg::RG_LEAK:   if (a < NP) coef[a] = int'(d);
      lnte_pkg::RG_GAIN:   if (a < NP) coef[GAIN_OFS + a] = int'(d);
      lnte_pkg::RG_WEIGHT: if (a < NP*NP) coef[WGT_OFS + a] = int'(d);
      lnte_pkg::RG_DECAY:  if (a < NP*NP) coef[DCY_OFS + a] = int'(d);
      default: ;
    endcase
  endtask

  task automatic tick_network(output spike_res_t res[$]);
    int cnt, p, v, c, t, idx, spikes, listed;
    longint nv, sum;
    int unsigned s, e;
    spike_res_t r;
    res = {};
    spikes = 0;
    listed = 0;
    cnt = (m_count > NN) ? NN : int'(m_count);
    for (int n = 0; n < cnt; n++) begin
      p = pop_of(n);
      v = volt[n];
      nv = longint'(v) + mul_q(coef[GAIN_OFS + p], inp[n]) - mul_q(coef[p], v);
      v = sat32(nv);
      if (v >= ONE_Q) begin
        v = 0;
        spikes++;
        if (listed < LMAX) begin
          r = '{neuron: lnte_pkg::NOUT_W'(n), total: '0, last: 1'b0, ovf: 1'b0};
          res.push_back(r);
          listed++;
        end
        s = fstart[n];
        e = s + flen[n];
        for (int unsigned l = s; l < e && l < NS; l++) begin
          t = tgt[l];
          if (t < cnt) begin
            idx = p * NN + t;
            cur[idx] = sat32(longint'(cur[idx]) + coef[WGT_OFS + pop_of(t) * NP + p]);
          end
        end
      end
      volt[n] = v;
    end
    for (int n = 0; n < cnt; n++) begin
      p = pop_of(n);
      sum = drv[n];
      for (int q = 0; q < NP; q++) begin
        if (coef[WGT_OFS + p * NP + q] != 0) begin
          idx = q * NN + n;
          c = sat32(mul_q(coef[DCY_OFS + p * NP + q], cur[idx]));
          cur[idx] = c;
          sum += c;
        end
      end
      inp[n] = sat32(sum);
    end
    r = '{neuron: '0, total: lnte_pkg::CFG_W'((spikes > 2047) ? 2047 : spikes), last: 1'b1,
          ovf: spikes > LMAX};
    res.push_back(r);
  endtask

  // called at a falling edge; returns at a falling edge
  task automatic send_request(row_t rw);
    spike_res_t res[$];
    start = 1'b1;
    in_command = rw.cmd;
    in_region = rw.region;
    in_address = rw.addr;
    in_data = rw.data;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (rw.cmd == CMD_TICK) begin
      n_ticks++;
      tick_network(res);
      if (rw.typed) begin
        spike_q.push_back('{neuron: '0, total: rw.typed_total, last: 1'b1,
                            ovf: rw.typed_ovf});
      end else begin
        foreach (res[i]) spike_q.push_back(res[i]);
      end
    end else begin
      n_writes++;
      table_write(rw.region, rw.addr, rw.data);
    end
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    start = 1'b0;
    while (spike_q.size() != 0 || busy) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic cfg_write(bit [lnte_pkg::CIDX_W-1:0] idx, bit [lnte_pkg::CFG_W-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      lnte_pkg::CFG_COUNT: m_count = val;
      lnte_pkg::CFG_POP1:  m_pop1 = val;
      lnte_pkg::CFG_POP2:  m_pop2 = val;
      default:             m_pop3 = val;
    endcase
  endtask

  function automatic row_t wr(bit [lnte_pkg::REGN_W-1:0] rg, bit [lnte_pkg::ADDR_W-1:0] a,
                              bit [31:0] d);
    row_t rw;
    rw = '{cmd: CMD_WRITE, region: rg, addr: a, data: d, typed: 1'b0, typed_total: '0,
           typed_ovf: 1'b0};
    return rw;
  endfunction

  function automatic row_t random_row();
    row_t rw;
    int cnt, k;
    bit [lnte_pkg::REGN_W-1:0] rg;
    bit [lnte_pkg::ADDR_W-1:0] a;
    bit [31:0] d;
    cnt = (m_count == 0) ? 1 : ((m_count > NN) ? NN : int'(m_count));
    if ($urandom_range(0, 99) < 15) begin
      rw = wr(lnte_pkg::RG_VOLT, '0, '0);
      rw.cmd = CMD_TICK;
      rw.region = lnte_pkg::REGN_W'($urandom);
      rw.addr = lnte_pkg::ADDR_W'($urandom);
      rw.data = $urandom;
      return rw;
    end
    k = $urandom_range(0, 99);
    if (k < 5) rg = lnte_pkg::REGN_W'(lnte_pkg::RG_DECAY + $urandom_range(1, 6));
    else rg = lnte_pkg::REGN_W'($urandom_range(lnte_pkg::RG_VOLT, lnte_pkg::RG_DECAY));
    a = lnte_pkg::ADDR_W'($urandom);
    d = $urandom;
    case (rg)
      lnte_pkg::RG_VOLT, lnte_pkg::RG_INPUT, lnte_pkg::RG_DRIVE: begin
        if ($urandom_range(0, 9) != 0) a = lnte_pkg::ADDR_W'($urandom_range(0, cnt - 1));
        if ($urandom_range(0, 9) != 0) d = $urandom_range(0, 3 * ONE_Q) - ONE_Q;
      end
      lnte_pkg::RG_START: begin
        if ($urandom_range(0, 9) != 0) a = lnte_pkg::ADDR_W'($urandom_range(0, cnt - 1));
        d[15:0] = 16'($urandom_range(0, 200));
      end
      lnte_pkg::RG_LENGTH: begin
        if ($urandom_range(0, 9) != 0) a = lnte_pkg::ADDR_W'($urandom_range(0, cnt - 1));
        d[15:0] = 16'($urandom_range(0, 55));
      end
      lnte_pkg::RG_TARGET:
        if ($urandom_range(0, 1) != 0) a = lnte_pkg::ADDR_W'($urandom_range(0, 255));
      lnte_pkg::RG_LEAK, lnte_pkg::RG_GAIN: begin
        if ($urandom_range(0, 9) != 0) a = lnte_pkg::ADDR_W'($urandom_range(0, NP - 1));
        if ($urandom_range(0, 9) != 0)
          d = (rg == lnte_pkg::RG_LEAK) ? $urandom_range(0, ONE_Q / 2)
                                        : $urandom_range(0, ONE_Q);
      end
      lnte_pkg::RG_WEIGHT, lnte_pkg::RG_DECAY: begin
        if ($urandom_range(0, 9) != 0) a = lnte_pkg::ADDR_W'($urandom_range(0, NP * NP - 1));
        if ($urandom_range(0, 9) != 0)
          d = (rg == lnte_pkg::RG_WEIGHT) ? $urandom_range(0, ONE_Q) - ONE_Q / 2
                                          : $urandom_range(0, ONE_Q);
      end
      default: ;
    endcase
    return wr(rg, a, d);
  endfunction

  always @(posedge clk) begin
    spike_res_t ex;
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      n_results++;
      if (spike_q.size() == 0) begin
        $display("%0t: unexpected result neuron=%0d total=%0d last=%0b ovf=%0b", $time,
                 out_neuron, out_spike_total, out_last, out_overflow);
        errors++;
      end else begin
        ex = spike_q.pop_front();
        if (out_neuron !== ex.neuron || out_spike_total !== ex.total ||
            out_last !== ex.last || out_overflow !== ex.ovf) begin
          $display("%0t: mismatch expected neuron=%0d total=%0d last=%0b ovf=%0b", $time,
                   ex.neuron, ex.total, ex.last, ex.ovf);
          $display("%0t:          actual   neuron=%0d total=%0d last=%0b ovf=%0b", $time,
                   out_neuron, out_spike_total, out_last, out_overflow);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  int phase_cfg [8][4] = '{
    '{32, 8, 16, 24}, '{1, 0, 0, 0}, '{0, 5, 5, 5}, '{64, 2047, 2047, 2047},
    '{2047, 900, 600, 300}, '{16, 10, 3, 12}, '{48, 0, 24, 2047},
    '{1024, 800, 1024, 1024}
  };

  initial begin
    row_t dir [$];
    row_t rw;
    for (int i = 0; i < NN; i++) begin
      volt[i] = 0; inp[i] = 0; drv[i] = 0; fstart[i] = 0; flen[i] = 0;
    end
    foreach (cur[i]) cur[i] = 0;
    foreach (tgt[i]) tgt[i] = 0;
    foreach (coef[i]) coef[i] = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // load drive, fan-out start and length for every neuron, and targets 0 to 255 and 65535
    idle_on = 1'b0;
    for (int i = 0; i < NN; i++) begin
      send_request(wr(lnte_pkg::RG_DRIVE, lnte_pkg::ADDR_W'(i),
                      $urandom_range(0, 5 * ONE_Q / 2) - ONE_Q / 2));
      send_request(wr(lnte_pkg::RG_START, lnte_pkg::ADDR_W'(i),
                      {16'($urandom), 16'($urandom_range(0, 200))}));
      send_request(wr(lnte_pkg::RG_LENGTH, lnte_pkg::ADDR_W'(i),
                      {16'($urandom), 16'($urandom_range(0, 8))}));
    end
    for (int i = 0; i < 256; i++) begin
      send_request(wr(lnte_pkg::RG_TARGET, lnte_pkg::ADDR_W'(i), $urandom));
    end
    send_request(wr(lnte_pkg::RG_TARGET, 16'hFFFF, $urandom));
    idle_on = 1'b1;

    rw = wr(lnte_pkg::RG_VOLT, '0, '0);
    rw.cmd = CMD_TICK; rw.typed = 1'b1; rw.typed_total = '0; rw.typed_ovf = 1'b0;
    dir.push_back(rw);
    dir.push_back(wr(lnte_pkg::RG_GAIN, 16'd0, 32'h0100_0000));
    dir.push_back(wr(lnte_pkg::RG_GAIN, 16'd1, 32'h7FFF_FFFF));
    dir.push_back(wr(lnte_pkg::RG_LEAK, 16'd0, 32'h0010_0000));
    dir.push_back(wr(lnte_pkg::RG_LEAK, 16'd3, 32'h8000_0000));
    dir.push_back(wr(lnte_pkg::RG_WEIGHT, 16'd0, 32'h0080_0000));
    dir.push_back(wr(lnte_pkg::RG_WEIGHT, 16'd15, 32'h7FFF_FFFF));
    dir.push_back(wr(lnte_pkg::RG_DECAY, 16'd0, 32'h00C0_0000));
    dir.push_back(wr(lnte_pkg::RG_DECAY, 16'd15, 32'h8000_0000));
    dir.push_back(wr(lnte_pkg::RG_VOLT, 16'd0, 32'h7FFF_FFFF));
    dir.push_back(wr(lnte_pkg::RG_VOLT, 16'd1, 32'h8000_0000));
    dir.push_back(wr(lnte_pkg::RG_VOLT, 16'd2, 32'h0100_0000));
    dir.push_back(wr(lnte_pkg::RG_VOLT, 16'd1023, 32'h00FF_FFFF));
    dir.push_back(wr(lnte_pkg::RG_INPUT, 16'd3, 32'h7FFF_FFFF));
    dir.push_back(wr(lnte_pkg::RG_START, 16'd5, 32'hFFFF_FFFF));
    dir.push_back(wr(lnte_pkg::RG_LENGTH, 16'd5, 32'hFFFF_FFFF));
    dir.push_back(wr(lnte_pkg::REGN_W'(lnte_pkg::RG_DECAY + 1), 16'd0, 32'hFFFF_FFFF));
    dir.push_back(wr(lnte_pkg::REGN_W'(lnte_pkg::RG_DECAY + 6), 16'hFFFF, 32'h1234_5678));
    dir.push_back(wr(lnte_pkg::RG_VOLT, 16'd1024, 32'h7FFF_FFFF));
    dir.push_back(wr(lnte_pkg::RG_LEAK, 16'd4, 32'h7FFF_FFFF));
    dir.push_back(wr(lnte_pkg::RG_WEIGHT, 16'd16, 32'h7FFF_FFFF));
    rw.typed = 1'b0;
    dir.push_back(rw);
    dir.push_back(rw);
    dir.push_back(wr(lnte_pkg::RG_LENGTH, 16'd5, 32'h0000_0002));
    foreach (dir[i]) send_request(dir[i]);

    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      for (int r = 0; r < 4; r++) begin
        cfg_write(lnte_pkg::CIDX_W'(r), lnte_pkg::CFG_W'(phase_cfg[ph][r]));
      end
      idle_on = (ph != 7);
      for (int i = 0; i < 31; i++) send_request(random_row());
    end

    start = 1'b0;
    while (spike_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    $display("covered %0d table writes and %0d ticks, %0d results checked", n_writes,
             n_ticks, n_results);
    $display("eight register settings including zero and maximum neuron counts");
    if (errors == 0 && spike_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
